// ===== hdl/mpd_pkg.sv =====
// mpd_pkg: shared types and constants for the mqtt packet deframer
// no dependencies; imported by every module of the block
package mpd_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned TYPE_W = 4;
   localparam int unsigned ROLE_W = 3;
   localparam int unsigned LEN_W = 28;
   localparam int unsigned TOPIC_W = 16;
   localparam int unsigned LEN_DIGIT_W = 7;

   localparam logic [TYPE_W-1:0] TYPE_CONNACK = 4'd2;
   localparam logic [TYPE_W-1:0] TYPE_PUBLISH = 4'd3;

   localparam logic [BYTE_W-1:0] LEN_DIGIT_MASK = 8'h7F;
   localparam logic [BYTE_W-1:0] LEN_CONT_MASK = 8'h80;
   localparam logic [2:0] LEN_LAST_INDEX = 3'd3;

   typedef enum logic [ROLE_W-1:0] {
      ROLE_HEADER = 3'd0,
      ROLE_LENGTH = 3'd1,
      ROLE_TOPIC_LEN = 3'd2,
      ROLE_TOPIC = 3'd3,
      ROLE_PACKET_ID = 3'd4,
      ROLE_PAYLOAD = 3'd5,
      ROLE_CONNACK_CODE = 3'd6,
      ROLE_OTHER_BODY = 3'd7
   } role_type;

   typedef struct packed {
      logic [TYPE_W-1:0] packet_type;
      role_type byte_role;
      logic [BYTE_W-1:0] data_byte;
      logic end_of_packet;
      logic [LEN_W-1:0] remaining_length;
      logic [TOPIC_W-1:0] topic_length;
      logic connack_accepted;
   } result_type;

endpackage

// ===== hdl/mpd_in_stage.sv =====
// mpd_in_stage: input beat register with valid and stall handshake
// uses mpd_pkg for the byte width
module mpd_in_stage
   import mpd_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input logic [BYTE_W-1:0] req_rx_byte,
   input logic advance,
   output logic held_valid,
   output logic [BYTE_W-1:0] held_byte
);

   logic valid_ff, valid_in;
   logic [BYTE_W-1:0] byte_ff;
   logic take;

   assign req_stall = valid_ff && !advance;
   assign take = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         byte_ff <= req_rx_byte;
      end
   end

   assign held_valid = valid_ff;
   assign held_byte = byte_ff;

endmodule

// ===== hdl/mpd_parser.sv =====
// mpd_parser: packet parse state and the per-byte tagging logic
// uses mpd_pkg for role codes, widths and the result struct
module mpd_parser
   import mpd_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic step,
   input logic [BYTE_W-1:0] rx_byte,
   output result_type result
);

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_LENGTH = 2'd1,
      PH_BODY = 2'd2
   } phase_type;

   phase_type phase_ff, phase_in;
   logic [TYPE_W-1:0] type_ff, type_in;
   logic [1:0] qos_ff, qos_in;
   logic [LEN_W-1:0] accum_ff, accum_in;
   logic [2:0] seen_ff, seen_in;
   logic [LEN_W-1:0] body_left_ff, body_left_in;
   logic [1:0] offset_ff, offset_in;
   logic [TOPIC_W-1:0] topic_len_ff, topic_len_in;
   logic [TOPIC_W-1:0] topic_left_ff, topic_left_in;
   logic [1:0] id_left_ff, id_left_in;

   logic [LEN_W-1:0] digit;
   role_type role;
   logic eop;
   logic accepted;

   always_comb begin
      phase_in = phase_ff;
      type_in = type_ff;
      qos_in = qos_ff;
      accum_in = accum_ff;
      seen_in = seen_ff;
      body_left_in = body_left_ff;
      offset_in = offset_ff;
      topic_len_in = topic_len_ff;
      topic_left_in = topic_left_ff;
      id_left_in = id_left_ff;
      role = ROLE_HEADER;
      eop = 1'b0;
      accepted = 1'b0;
      digit = {{(LEN_W-LEN_DIGIT_W){1'b0}}, rx_byte[LEN_DIGIT_W-1:0]};

      unique case (phase_ff)
         PH_LENGTH: begin
            case (seen_ff[1:0])
               2'd0: accum_in = accum_ff | digit;
               2'd1: accum_in = accum_ff | (digit << LEN_DIGIT_W);
               2'd2: accum_in = accum_ff | (digit << (2*LEN_DIGIT_W));
               default: accum_in = accum_ff | (digit << (3*LEN_DIGIT_W));
            endcase
            seen_in = seen_ff + 3'd1;
            role = ROLE_LENGTH;
            if ((rx_byte & LEN_CONT_MASK) == '0 || seen_ff >= LEN_LAST_INDEX) begin
               if (accum_in == '0) begin
                  eop = 1'b1;
                  phase_in = PH_HEADER;
               end else begin
                  body_left_in = accum_in;
                  phase_in = PH_BODY;
               end
            end
         end
         PH_BODY: begin
            if (type_ff == TYPE_PUBLISH) begin
               if (offset_ff == 2'd0) begin
                  topic_len_in = {rx_byte, 8'h00};
                  offset_in = 2'd1;
                  role = ROLE_TOPIC_LEN;
               end else if (offset_ff == 2'd1) begin
                  topic_len_in = {topic_len_ff[TOPIC_W-1:BYTE_W], rx_byte};
                  topic_left_in = topic_len_in;
                  id_left_in = (qos_ff != 2'd0) ? 2'd2 : 2'd0;
                  offset_in = 2'd2;
                  role = ROLE_TOPIC_LEN;
               end else if (topic_left_ff != '0) begin
                  topic_left_in = topic_left_ff - 16'd1;
                  role = ROLE_TOPIC;
               end else if (id_left_ff != 2'd0) begin
                  id_left_in = id_left_ff - 2'd1;
                  role = ROLE_PACKET_ID;
               end else begin
                  role = ROLE_PAYLOAD;
               end
            end else if (type_ff == TYPE_CONNACK) begin
               if (offset_ff == 2'd1) begin
                  role = ROLE_CONNACK_CODE;
                  accepted = (rx_byte == '0);
               end else begin
                  role = ROLE_OTHER_BODY;
               end
               if (offset_ff < 2'd2) begin
                  offset_in = offset_ff + 2'd1;
               end
            end else begin
               role = ROLE_OTHER_BODY;
            end
            if (body_left_ff != '0) begin
               body_left_in = body_left_ff - 28'd1;
            end
            if (body_left_in == '0) begin
               eop = 1'b1;
               phase_in = PH_HEADER;
            end
         end
         default: begin
            type_in = rx_byte[7:4];
            qos_in = rx_byte[2:1];
            accum_in = '0;
            seen_in = '0;
            body_left_in = '0;
            offset_in = '0;
            topic_len_in = '0;
            topic_left_in = '0;
            id_left_in = '0;
            role = ROLE_HEADER;
            phase_in = PH_LENGTH;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         type_ff <= '0;
         qos_ff <= '0;
         accum_ff <= '0;
         seen_ff <= '0;
         body_left_ff <= '0;
         offset_ff <= '0;
         topic_len_ff <= '0;
         topic_left_ff <= '0;
         id_left_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         type_ff <= type_in;
         qos_ff <= qos_in;
         accum_ff <= accum_in;
         seen_ff <= seen_in;
         body_left_ff <= body_left_in;
         offset_ff <= offset_in;
         topic_len_ff <= topic_len_in;
         topic_left_ff <= topic_left_in;
         id_left_ff <= id_left_in;
      end
   end

   always_comb begin
      result.packet_type = type_in;
      result.byte_role = role;
      result.data_byte = rx_byte;
      result.end_of_packet = eop;
      result.remaining_length = accum_in;
      result.topic_length = topic_len_in;
      result.connack_accepted = accepted;
   end

endmodule

// ===== hdl/mqtt_packet_deframer.sv =====
// an accepted input beat passes through the input register, the parser and then the result register
// throughput: one byte per cycle while rsp_stall is low, set by the single parse step between the registers
// the input register takes a new byte, if it is empty, while a finished result waits on rsp_stall
// reset (synchronous, active high) empties both registers and returns the parser to header
// uses mpd_pkg, mpd_in_stage and mpd_parser
module mqtt_packet_deframer
   import mpd_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input logic [BYTE_W-1:0] req_rx_byte,
   output logic rsp_valid,
   input logic rsp_stall,
   output logic [TYPE_W-1:0] rsp_packet_type,
   output logic [ROLE_W-1:0] rsp_byte_role,
   output logic [BYTE_W-1:0] rsp_data_byte,
   output logic rsp_end_of_packet,
   output logic [LEN_W-1:0] rsp_remaining_length,
   output logic [TOPIC_W-1:0] rsp_topic_length,
   output logic rsp_connack_accepted
);

   logic held_valid;
   logic [BYTE_W-1:0] held_byte;
   logic advance;
   result_type result;
   result_type rsp_ff;
   logic rsp_valid_ff, rsp_valid_in;

   assign advance = held_valid && (!rsp_valid_ff || !rsp_stall);

   mpd_in_stage u_in_stage (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_rx_byte(req_rx_byte),
      .advance(advance),
      .held_valid(held_valid),
      .held_byte(held_byte)
   );

   mpd_parser u_parser (
      .clock(clock),
      .reset(reset),
      .step(advance),
      .rx_byte(held_byte),
      .result(result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_packet_type = rsp_ff.packet_type;
   assign rsp_byte_role = rsp_ff.byte_role;
   assign rsp_data_byte = rsp_ff.data_byte;
   assign rsp_end_of_packet = rsp_ff.end_of_packet;
   assign rsp_remaining_length = rsp_ff.remaining_length;
   assign rsp_topic_length = rsp_ff.topic_length;
   assign rsp_connack_accepted = rsp_ff.connack_accepted;

endmodule

// ===== hdl/mpd_checker.sv =====
// mpd_checker: port-level checks on the result channel of the deframer
// uses mpd_pkg role codes; bound to mqtt_packet_deframer below
module mpd_checker
   import mpd_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic [ROLE_W-1:0] rsp_byte_role,
   input logic [BYTE_W-1:0] rsp_data_byte,
   input logic rsp_end_of_packet,
   input logic [LEN_W-1:0] rsp_remaining_length,
   input logic [TOPIC_W-1:0] rsp_topic_length,
   input logic rsp_connack_accepted
);

   a_hold_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data_byte)
         && $stable(rsp_byte_role))
      else $error("stalled result beat changed");

   a_header_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_byte_role == ROLE_HEADER |->
         !rsp_end_of_packet && rsp_remaining_length == '0 && rsp_topic_length == '0)
      else $error("header beat carries packet state");

   a_connack_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_byte_role == ROLE_CONNACK_CODE |->
         rsp_connack_accepted == (rsp_data_byte == '0))
      else $error("connack accepted flag wrong");

   a_accept_only_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_connack_accepted |-> rsp_byte_role == ROLE_CONNACK_CODE)
      else $error("accepted flag outside connack code");

   a_header_follows_eop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_end_of_packet ##1 rsp_valid |->
         rsp_byte_role == ROLE_HEADER)
      else $error("byte after end of packet is not a header");

endmodule

bind mqtt_packet_deframer mpd_checker u_mpd_checker (
   .clock(clock),
   .reset(reset),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_byte_role(rsp_byte_role),
   .rsp_data_byte(rsp_data_byte),
   .rsp_end_of_packet(rsp_end_of_packet),
   .rsp_remaining_length(rsp_remaining_length),
   .rsp_topic_length(rsp_topic_length),
   .rsp_connack_accepted(rsp_connack_accepted)
);
